// ===== src/bsb_pkg.sv =====
`default_nettype none
package bsb_pkg;

	localparam int MAX_ROWS_D = 64;
	localparam int MAX_COLS_D = 64;
	localparam int CFG_W = 7;
	localparam int LEN_W = 7;
	localparam int LEN_SAT = 127;

	// configuration register indexes
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_CLR,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_SCAN_RD,
		OP_SCAN_EV,
		OP_SEED,
		OP_BRIDGE_INIT,
		OP_POP_EV,
		OP_NB_RD,
		OP_NB_EV,
		OP_REPORT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic bridge;
		logic found;
	} cmd_t;

	typedef struct packed {
		logic cfg_dirty;
		logic clr_last;
		logic div_last;
		logic scan_land;
		logic scan_last;
		logic q_empty;
		logic hit;
		logic k_last;
		logic out_busy;
	} sts_t;

	// 0 acts as 1, above the maximum acts as the maximum
	function automatic int clamp_size(logic [CFG_W-1:0] v, int mx);
		int r;
		r = int'(v);
		if (r < 1) r = 1;
		if (r > mx) r = mx;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/bsb_if.sv =====
`default_nettype none
interface bsb_cell_if;
	logic valid;
	logic ready;
	logic is_land;
	logic last_cell;
	modport source (output valid, is_land, last_cell, input ready);
	modport sink (input valid, is_land, last_cell, output ready);
endinterface

interface bsb_res_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [6:0] bridge_length;
	modport source (output valid, found, bridge_length, input ready);
	modport sink (input valid, found, bridge_length, output ready);
endinterface

interface bsb_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/bsb_ctrl.sv =====
`default_nettype none
module bsb_ctrl
	import bsb_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	input  wire  in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_LOAD    = 4'd1;
	localparam logic [3:0] ST_DIV_INI = 4'd2;
	localparam logic [3:0] ST_DIV     = 4'd3;
	localparam logic [3:0] ST_SCAN_RD = 4'd4;
	localparam logic [3:0] ST_SCAN_EV = 4'd5;
	localparam logic [3:0] ST_SEED    = 4'd6;
	localparam logic [3:0] ST_POP_RD  = 4'd7;
	localparam logic [3:0] ST_POP_EV  = 4'd8;
	localparam logic [3:0] ST_LAND    = 4'd9;
	localparam logic [3:0] ST_NB_RD   = 4'd10;
	localparam logic [3:0] ST_NB_EV   = 4'd11;
	localparam logic [3:0] ST_REPORT  = 4'd12;

	logic [3:0] state_q, state_d;
	logic       bridge_q, bridge_d;
	logic       found_q, found_d;

	assign in_ready = (state_q == ST_LOAD) && !sts.cfg_dirty;

	always_comb begin
		state_d = state_q;
		bridge_d = bridge_q;
		found_d = found_q;
		cmd.op = OP_IDLE;
		cmd.bridge = bridge_q;
		cmd.found = found_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLR;
				if (sts.clr_last) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.cfg_dirty) begin
					state_d = ST_DIV_INI;
				end else if (in_valid) begin
					cmd.op = OP_LOAD;
					if (in_last) state_d = ST_SCAN_RD;
				end
			end
			ST_DIV_INI: begin
				cmd.op = OP_DIV_INIT;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (sts.div_last) state_d = ST_LOAD;
			end
			ST_SCAN_RD: begin
				cmd.op = OP_SCAN_RD;
				state_d = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				cmd.op = OP_SCAN_EV;
				if (sts.scan_land) begin
					state_d = ST_SEED;
				end else if (sts.scan_last) begin
					found_d = 1'b0;
					state_d = ST_REPORT;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SEED: begin
				cmd.op = OP_SEED;
				bridge_d = 1'b0;
				state_d = ST_POP_RD;
			end
			ST_POP_RD: begin
				if (sts.q_empty) begin
					if (!bridge_q) begin
						cmd.op = OP_BRIDGE_INIT;
						bridge_d = 1'b1;
					end else begin
						found_d = 1'b0;
						state_d = ST_REPORT;
					end
				end else begin
					state_d = ST_POP_EV;
				end
			end
			ST_POP_EV: begin
				cmd.op = OP_POP_EV;
				state_d = ST_LAND;
			end
			ST_LAND: begin
				if (bridge_q && sts.hit) begin
					found_d = 1'b1;
					state_d = ST_REPORT;
				end else begin
					state_d = ST_NB_RD;
				end
			end
			ST_NB_RD: begin
				cmd.op = OP_NB_RD;
				state_d = ST_NB_EV;
			end
			ST_NB_EV: begin
				cmd.op = OP_NB_EV;
				state_d = sts.k_last ? ST_POP_RD : ST_NB_RD;
			end
			ST_REPORT: begin
				if (!sts.out_busy) begin
					cmd.op = OP_REPORT;
					state_d = ST_CLEAR;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			bridge_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bridge_q <= bridge_d;
			found_q <= found_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/bsb_dp.sv =====
`default_nettype none
module bsb_dp
	import bsb_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_D,
	parameter int MAX_COLS = MAX_COLS_D
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        is_land,
	input  cmd_t       cmd,
	output sts_t       sts,
	bsb_cfg_if.sink    cfg,
	bsb_res_if.source  result
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int AW = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int RW1 = $clog2(MAX_ROWS + 1);
	localparam int CW1 = $clog2(MAX_COLS + 1);
	localparam int LW = $clog2(MAX_ROWS * MAX_COLS + 1);
	localparam int DCW = (LW > 1) ? $clog2(LW) : 1;
	localparam int QW = AW + LW;

	// sizes and load position
	logic [RW1-1:0] rows_q;
	logic [CW1-1:0] cols_q;
	logic           dirty_q;
	logic [LW-1:0]  cap_q, ld_cnt_q, ld_r_q;
	logic [CW1-1:0] ld_c_q;
	logic           ld_ok;

	// load position recalculation
	logic [LW-1:0]  div_n_q, quo_q, quo_nx;
	logic [CW1-1:0] rem_q;
	logic [CW1:0]   rem_sh, rem_nx;
	logic           ge;
	logic [DCW-1:0] div_cnt_q;

	// search state
	logic [AW-1:0]  clr_q;
	logic [RW-1:0]  sr_q;
	logic [CW-1:0]  sc_q;
	logic [AW:0]    head_q, tail_q;
	logic [AW-1:0]  p_q;
	logic [LW-1:0]  d_q;
	logic [1:0]     k_q;
	logic [AW-1:0]  nb_addr, nb_addr_q;
	logic           nb_ok, nb_ok_q;
	logic [RW-1:0]  pr;
	logic [CW-1:0]  pc;
	logic           enq;

	// memories
	logic           land_mem [DEPTH];
	logic           vis_mem [DEPTH];
	logic [QW-1:0]  q_mem [DEPTH];
	logic           land_rd_q, vis_rd_q;
	logic [QW-1:0]  q_rd_q;
	logic [AW-1:0]  raddr;
	logic           land_we, land_wd, vis_we, vis_wd, q_we;
	logic [AW-1:0]  land_wa, vis_wa, q_wa;
	logic [QW-1:0]  q_wd;
	logic [AW-1:0]  q_pos;
	logic [LW-1:0]  q_dist, dm1;

	// result
	logic           res_valid_q, res_found_q;
	logic [LEN_W-1:0] res_len_q;

	assign cfg.ready = 1'b1;
	assign result.valid = res_valid_q;
	assign result.found = res_found_q;
	assign result.bridge_length = res_len_q;

	assign ld_ok = ld_cnt_q < cap_q;
	assign q_pos = q_rd_q[QW-1:LW];
	assign q_dist = q_rd_q[LW-1:0];
	assign pr = p_q[AW-1:CW];
	assign pc = p_q[CW-1:0];
	assign enq = nb_ok_q && !vis_rd_q && (cmd.bridge || land_rd_q);
	assign dm1 = d_q - LW'(1);

	assign rem_sh = {rem_q, div_n_q[LW-1]};
	assign ge = rem_sh >= {1'b0, cols_q};
	assign rem_nx = ge ? rem_sh - {1'b0, cols_q} : rem_sh;
	assign quo_nx = LW'({quo_q, ge});

	// neighbour k of the cell being expanded: up, down, left, right
	always_comb begin
		nb_ok = 1'b0;
		nb_addr = p_q;
		unique case (k_q)
			2'd0: begin
				nb_ok = pr != '0;
				nb_addr = {pr - RW'(1), pc};
			end
			2'd1: begin
				nb_ok = (32'(pr) + 32'd1) < 32'(rows_q);
				nb_addr = {pr + RW'(1), pc};
			end
			2'd2: begin
				nb_ok = pc != '0;
				nb_addr = {pr, pc - CW'(1)};
			end
			2'd3: begin
				nb_ok = (32'(pc) + 32'd1) < 32'(cols_q);
				nb_addr = {pr, pc + CW'(1)};
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		raddr = '0;
		land_we = 1'b0;
		land_wa = clr_q;
		land_wd = 1'b0;
		vis_we = 1'b0;
		vis_wa = clr_q;
		vis_wd = 1'b0;
		q_we = 1'b0;
		q_wa = tail_q[AW-1:0];
		q_wd = {nb_addr_q, cmd.bridge ? d_q + LW'(1) : LW'(0)};
		unique case (cmd.op)
			OP_LOAD: begin
				land_we = ld_ok;
				land_wa = {ld_r_q[RW-1:0], ld_c_q[CW-1:0]};
				land_wd = is_land;
			end
			OP_CLR: begin
				land_we = 1'b1;
				vis_we = 1'b1;
			end
			OP_SCAN_RD: raddr = {sr_q, sc_q};
			OP_SEED: begin
				vis_we = 1'b1;
				vis_wa = {sr_q, sc_q};
				vis_wd = 1'b1;
				q_we = 1'b1;
				q_wa = '0;
				q_wd = {sr_q, sc_q, LW'(0)};
			end
			OP_POP_EV: raddr = q_pos;
			OP_NB_RD: raddr = nb_addr;
			OP_NB_EV: begin
				vis_we = enq;
				vis_wa = nb_addr_q;
				vis_wd = 1'b1;
				q_we = enq;
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (land_we) land_mem[land_wa] <= land_wd;
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		if (q_we) q_mem[q_wa] <= q_wd;
		land_rd_q <= land_mem[raddr];
		vis_rd_q <= vis_mem[raddr];
		q_rd_q <= q_mem[head_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RW1'(MAX_ROWS);
			cols_q <= CW1'(MAX_COLS);
			dirty_q <= 1'b1;
			cap_q <= '0;
			ld_cnt_q <= '0;
			ld_r_q <= '0;
			ld_c_q <= '0;
			div_n_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			div_cnt_q <= '0;
			clr_q <= '0;
			sr_q <= '0;
			sc_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			p_q <= '0;
			d_q <= '0;
			k_q <= '0;
			nb_addr_q <= '0;
			nb_ok_q <= 1'b0;
			res_valid_q <= 1'b0;
			res_found_q <= 1'b0;
			res_len_q <= '0;
		end else begin
			if (result.ready) res_valid_q <= 1'b0;
			if (cmd.op == OP_DIV_INIT) dirty_q <= 1'b0;
			if (cfg.valid) begin
				dirty_q <= 1'b1;
				unique case (cfg.index)
					REG_ROWS: rows_q <= RW1'(clamp_size(cfg.data, MAX_ROWS));
					REG_COLS: cols_q <= CW1'(clamp_size(cfg.data, MAX_COLS));
					default: ;
				endcase
			end
			unique case (cmd.op)
				OP_LOAD: begin
					if (ld_ok) begin
						ld_cnt_q <= ld_cnt_q + LW'(1);
						if ((32'(ld_c_q) + 32'd1) == 32'(cols_q)) begin
							ld_c_q <= '0;
							ld_r_q <= ld_r_q + LW'(1);
						end else begin
							ld_c_q <= ld_c_q + CW1'(1);
						end
					end
				end
				OP_CLR: clr_q <= clr_q + AW'(1);
				OP_DIV_INIT: begin
					cap_q <= LW'(32'(rows_q) * 32'(cols_q));
					div_n_q <= ld_cnt_q;
					quo_q <= '0;
					rem_q <= '0;
					div_cnt_q <= '0;
				end
				OP_DIV_STEP: begin
					div_n_q <= div_n_q << 1;
					quo_q <= quo_nx;
					rem_q <= rem_nx[CW1-1:0];
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (sts.div_last) begin
						ld_r_q <= quo_nx;
						ld_c_q <= rem_nx[CW1-1:0];
					end
				end
				OP_SCAN_EV: begin
					if (!land_rd_q) begin
						if ((32'(sc_q) + 32'd1) == 32'(cols_q)) begin
							sc_q <= '0;
							sr_q <= sr_q + RW'(1);
						end else begin
							sc_q <= sc_q + CW'(1);
						end
					end
				end
				OP_SEED: begin
					head_q <= '0;
					tail_q <= (AW+1)'(1);
				end
				OP_BRIDGE_INIT: head_q <= '0;
				OP_POP_EV: begin
					p_q <= q_pos;
					d_q <= q_dist;
					head_q <= head_q + (AW+1)'(1);
					k_q <= '0;
				end
				OP_NB_RD: begin
					nb_addr_q <= nb_addr;
					nb_ok_q <= nb_ok;
				end
				OP_NB_EV: begin
					k_q <= k_q + 2'd1;
					if (enq) tail_q <= tail_q + (AW+1)'(1);
				end
				OP_REPORT: begin
					res_valid_q <= 1'b1;
					res_found_q <= cmd.found;
					if (!cmd.found) res_len_q <= '0;
					else if (32'(dm1) > LEN_SAT) res_len_q <= LEN_W'(LEN_SAT);
					else res_len_q <= LEN_W'(dm1);
					ld_cnt_q <= '0;
					ld_r_q <= '0;
					ld_c_q <= '0;
					sr_q <= '0;
					sc_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign sts.cfg_dirty = dirty_q;
	assign sts.clr_last = clr_q == '1;
	assign sts.div_last = div_cnt_q == DCW'(LW - 1);
	assign sts.scan_land = land_rd_q;
	assign sts.scan_last = ((32'(sr_q) + 32'd1) == 32'(rows_q))
		&& ((32'(sc_q) + 32'd1) == 32'(cols_q));
	assign sts.q_empty = head_q == tail_q;
	assign sts.hit = land_rd_q && (d_q != '0);
	assign sts.k_last = k_q == 2'd3;
	assign sts.out_busy = res_valid_q;

`ifndef SYNTHESIS
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("queue head passed tail");
	a_report_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_REPORT |=> res_valid_q) else $error("result not posted");
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_found_q |-> res_len_q == '0) else $error("length without bridge");
	a_no_report_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_REPORT |-> !res_valid_q) else $error("result overwritten");
`endif

endmodule
`default_nettype wire

// ===== src/grid_shortest_bridge_bfs.sv =====
`default_nettype none
// Shortest bridge finder: grid cells stream in on the cells channel, one beat per cycle while
// the block is ready for cells, in row-major order, and each beat is written straight into the
// land map. The beat flagged last_cell starts the search: a scan for the first land cell
// (a read and a check per cell scanned), a flood fill of that island and then a multi-source
// breadth-first search from it, both through one shared cell queue (queue read, land check,
// then a read and a decide for each of the four neighbours per queued cell). One result beat
// follows and is held in an output register until taken. The land and visited maps are then
// wiped by a clearing pass of one entry per cycle over all 2^(RW+CW) map entries (4096 with
// the default 64 by 64 sizes); the same pass runs after reset, and no cell is taken during it.
// Size registers can be written at any time; a size write costs a recalculation of the load
// position (an init step, then a divide step per bit of the cell count) before the next cell.
module grid_shortest_bridge_bfs
	import bsb_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_D,
	parameter int MAX_COLS = MAX_COLS_D
) (
	input  wire       clk,
	input  wire       arst_n,
	bsb_cell_if.sink  cells,
	bsb_res_if.source result,
	bsb_cfg_if.sink   cfg
);

	// command and status between sequencer and datapath
	cmd_t cmd;
	sts_t sts;
	logic cell_ready;

	assign cells.ready = cell_ready;

	// sequencer: load, size recalculation, scan, flood, bridge search, report, clear
	bsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cells.valid),
		.in_last  (cells.last_cell),
		.in_ready (cell_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// maps, queue, size registers and result register
	bsb_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.is_land (cells.is_land),
		.cmd     (cmd),
		.sts     (sts),
		.cfg     (cfg),
		.result  (result)
	);

endmodule
`default_nettype wire
